// ----- rtl/sca_pkg.sv -----
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and constants of the size class packing allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package sca_pkg;

  localparam int unsigned MAX_LEN     = 64;
  localparam int unsigned MAX_HANDLES = 1024;
  localparam int unsigned MAX_SLOTS   = 256;

  localparam logic [12:0] CHUNK_RESET = 13'd4096;
  localparam logic [12:0] CHUNK_MAX   = 13'd4096;

  // Commands
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOCATE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_HDL   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_BAD_HDL  = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_in;     // capture the accepted item
    logic clr_step;  // clear one handle entry, seed one stack entry
    logic fetch;     // read handle entry and stack top
    logic rd_cnt;    // read the class count
    logic chk;       // check the item, latch class and slots
    logic div_go;    // start a placement division
    logic div_last;  // divide for the last slot rather than the item slot
    logic lat_dst;   // capture item placement
    logic lat_src;   // capture last item placement
    logic commit_a;  // first table update
    logic commit_b;  // second table update (moved handle)
    logic emit;      // load the result registers
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic err;
    logic is_remove;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/size_class_packing_allocator.sv -----
// ----------------------------------------------------------------------------
// size_class_packing_allocator
// Handle allocator packing items of each length back to back across chunks.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd, item_length and handle_in with start; the
//   command is taken on a clock edge where start is high and busy is low.
//   Result channel: one result per command, shown for one cycle with done
//   high. The receiver cannot stall; results must be taken as they come.
//   Config channel: cfg_valid/cfg_data write the chunk size; cfg_ready is
//   always high. Write only while busy is low and no result is pending.
// Sequence: error results (bad length, class full, no handle, bad handle)
//   go from the checks straight to the result. Create and locate run the
//   14-step chunk divider once for the item placement, remove runs it
//   twice. busy drops as done rises, so the next command can be taken at
//   the edge that ends the result cycle; no new command is taken while
//   the previous one is still in progress.
// Reset: rst (synchronous) starts a clearing pass over the handle table
//   and free stack; busy stays high until it ends. Config writes are
//   taken during the pass.
// ----------------------------------------------------------------------------
`default_nettype none
module size_class_packing_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [6:0]  item_length,
  input  wire logic [9:0]  handle_in,
  output logic             done,
  output logic [9:0]       handle_out,
  output logic [2:0]       status,
  output logic [13:0]      chunk_index,
  output logic [11:0]      offset,
  output logic [6:0]       first_len,
  output logic [6:0]       second_len,
  output logic [13:0]      src_chunk,
  output logic [11:0]      src_offset,
  output logic             moved_valid,
  output logic [9:0]       moved_handle,
  output logic             chunk_added,
  output logic             chunk_freed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data
);

  sca_pkg::ctl_t ctl;
  sca_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  sca_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .item_length  (item_length),
    .handle_in    (handle_in),
    .done         (done),
    .handle_out   (handle_out),
    .status       (status),
    .chunk_index  (chunk_index),
    .offset       (offset),
    .first_len    (first_len),
    .second_len   (second_len),
    .src_chunk    (src_chunk),
    .src_offset   (src_offset),
    .moved_valid  (moved_valid),
    .moved_handle (moved_handle),
    .chunk_added  (chunk_added),
    .chunk_freed  (chunk_freed)
  );

endmodule
`default_nettype wire

// ----- rtl/sca_div.sv -----
// ----------------------------------------------------------------------------
// sca_div
// Restoring divider: byte address by chunk size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sca_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [13:0] dividend,
  input  wire logic [12:0] divisor,
  output logic             done,
  output logic [13:0]      quot,
  output logic [11:0]      rem
);

  logic [12:0] rem_r;
  logic [13:0] quo_r;
  logic [3:0]  cnt;
  logic        run;
  logic [13:0] trial;
  logic        ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_r, quo_r[13]};
    ge    = trial >= {1'b0, divisor};
  end

  // Iterate fourteen steps
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 4'd1);
      if (go) begin
        run <= 1'b1;
        cnt <= 4'd14;
      end else if (run) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (run) begin
      rem_r <= ge ? 13'(trial - {1'b0, divisor}) : trial[12:0];
      quo_r <= {quo_r[12:0], ge};
    end
  end

  assign quot = quo_r;
  assign rem  = rem_r[11:0];

endmodule
`default_nettype wire

// ----- rtl/sca_ctrl.sv -----
// ----------------------------------------------------------------------------
// sca_ctrl
// Command sequencer: clear pass, table reads, checks, divisions, updates.
// ----------------------------------------------------------------------------
`default_nettype none
module sca_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire sca_pkg::sts_t sts,
  output logic               busy,
  output sca_pkg::ctl_t      ctl
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_HWAIT, S_CHK, S_GO1, S_DIV1,
    S_GO2, S_DIV2, S_WR1, S_WR2, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.ld_in  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        ctl.fetch  = 1'b1;
        state_next = S_HWAIT;
      end
      S_HWAIT: begin
        ctl.rd_cnt = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        ctl.chk    = 1'b1;
        state_next = sts.err ? S_OUT : S_GO1;
      end
      S_GO1: begin
        ctl.div_go = 1'b1;
        state_next = S_DIV1;
      end
      S_DIV1: begin
        if (sts.div_done) begin
          ctl.lat_dst = 1'b1;
          state_next  = sts.is_remove ? S_GO2 : S_WR1;
        end
      end
      S_GO2: begin
        ctl.div_go   = 1'b1;
        ctl.div_last = 1'b1;
        state_next   = S_DIV2;
      end
      S_DIV2: begin
        ctl.div_last = 1'b1;
        if (sts.div_done) begin
          ctl.lat_src = 1'b1;
          state_next  = S_WR1;
        end
      end
      S_WR1: begin
        ctl.commit_a = 1'b1;
        state_next   = S_WR2;
      end
      S_WR2: begin
        ctl.commit_b = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        ctl.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sca_dp.sv -----
// ----------------------------------------------------------------------------
// sca_dp
// Datapath: handle, owner, count and free stack tables, placement and results.
// ----------------------------------------------------------------------------
`default_nettype none
module sca_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sca_pkg::ctl_t ctl,
  output sca_pkg::sts_t      sts,
  input  wire logic          cfg_we,
  input  wire logic [12:0]   cfg_data,
  input  wire logic [1:0]    cmd,
  input  wire logic [6:0]    item_length,
  input  wire logic [9:0]    handle_in,
  output logic               done,
  output logic [9:0]         handle_out,
  output logic [2:0]         status,
  output logic [13:0]        chunk_index,
  output logic [11:0]        offset,
  output logic [6:0]         first_len,
  output logic [6:0]         second_len,
  output logic [13:0]        src_chunk,
  output logic [11:0]        src_offset,
  output logic               moved_valid,
  output logic [9:0]         moved_handle,
  output logic               chunk_added,
  output logic               chunk_freed
);

  // Tables
  logic [15:0] hmem  [sca_pkg::MAX_HANDLES];  // {valid, class, slot}
  logic [9:0]  omem  [sca_pkg::MAX_LEN * sca_pkg::MAX_SLOTS];
  logic [9:0]  smem  [sca_pkg::MAX_HANDLES];
  logic [8:0]  cmem  [sca_pkg::MAX_LEN];
  logic [sca_pkg::MAX_LEN-1:0] cnt_vld;

  logic [12:0] cbytes;
  logic [1:0]  cmd_q;
  logic [6:0]  len_q;
  logic [9:0]  hin_q;
  logic [15:0] hrd;
  logic [9:0]  stack_rd;
  logic [9:0]  owner_rd;
  logic [8:0]  cnt_rdm;
  logic        cnt_rdv;
  logic [10:0] free_top;
  logic [9:0]  clr_idx;
  logic [2:0]  stat_q;
  logic [6:0]  cls_q;
  logic [7:0]  slot_q;
  logic [7:0]  last_q;
  logic [13:0] dst_chunk;
  logic [11:0] dst_off;
  logic [13:0] src_chunk_q;
  logic [11:0] src_off_q;

  logic [8:0]  cnt_q;
  logic [6:0]  cls_sel;
  logic [5:0]  cls_idx;
  logic [8:0]  cnt_m1;
  logic        len_bad;
  logic        live;
  logic [2:0]  stat_now;
  logic        ok;
  logic        is_create;
  logic        is_remove;
  logic        moved;
  logic        push_ok;
  logic [12:0] cfg_clamp;

  logic        div_done;
  logic [13:0] div_quot;
  logic [11:0] div_rem;
  logic [13:0] prod;

  logic        h_we;
  logic [9:0]  h_wa;
  logic [15:0] h_wd;
  logic        o_we;
  logic [13:0] o_wa;
  logic [9:0]  o_wd;
  logic        c_we;
  logic [5:0]  c_wa;
  logic [8:0]  c_wd;
  logic        s_we;
  logic [9:0]  s_wa;
  logic [9:0]  s_wd;

  logic [12:0] room;
  logic [6:0]  first_c;

  // Chunk size register, clamp to 1..4096
  always_comb begin
    cfg_clamp = cfg_data;
    if (cfg_data == 13'd0) begin
      cfg_clamp = 13'd1;
    end else if (cfg_data > sca_pkg::CHUNK_MAX) begin
      cfg_clamp = sca_pkg::CHUNK_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cbytes <= sca_pkg::CHUNK_RESET;
    end else if (cfg_we) begin
      cbytes <= cfg_clamp;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      cmd_q <= cmd;
      len_q <= item_length;
      hin_q <= handle_in;
    end
  end

  // Checks
  always_comb begin
    is_create = (cmd_q == sca_pkg::CMD_CREATE);
    is_remove = (cmd_q == sca_pkg::CMD_REMOVE);
    cnt_q     = cnt_rdv ? cnt_rdm : 9'd0;
    cls_sel   = is_create ? len_q : hrd[14:8];
    cls_idx   = 6'(cls_sel - 7'd1);
    cnt_m1    = cnt_q - 9'd1;
    len_bad   = (len_q == 7'd0) || (len_q > 7'(sca_pkg::MAX_LEN))
                || ({6'd0, len_q} > cbytes);
    live      = hrd[15] && (hrd[14:8] != 7'd0) && (hrd[14:8] <= 7'(sca_pkg::MAX_LEN))
                && ({1'b0, hrd[7:0]} < cnt_q);
    if (is_create) begin
      if (len_bad) begin
        stat_now = sca_pkg::ST_BAD_LEN;
      end else if (cnt_q >= 9'(sca_pkg::MAX_SLOTS)) begin
        stat_now = sca_pkg::ST_FULL;
      end else if (free_top == 11'd0) begin
        stat_now = sca_pkg::ST_NO_HDL;
      end else begin
        stat_now = sca_pkg::ST_OK;
      end
    end else if ((is_remove || cmd_q == sca_pkg::CMD_LOCATE) && live) begin
      stat_now = sca_pkg::ST_OK;
    end else begin
      stat_now = sca_pkg::ST_BAD_HDL;
    end
    ok      = (stat_q == sca_pkg::ST_OK);
    moved   = (slot_q != last_q);
    push_ok = (free_top < 11'(sca_pkg::MAX_HANDLES));
  end

  assign sts.clr_last  = (clr_idx == 10'(sca_pkg::MAX_HANDLES - 1));
  assign sts.div_done  = div_done;
  assign sts.err       = (stat_now != sca_pkg::ST_OK);
  assign sts.is_remove = is_remove;

  // Latch check results
  always_ff @(posedge clk) begin
    if (ctl.chk) begin
      stat_q <= stat_now;
      cls_q  <= cls_sel;
      slot_q <= is_create ? cnt_q[7:0] : hrd[7:0];
      last_q <= cnt_m1[7:0];
    end
  end

  // Table reads
  always_ff @(posedge clk) begin
    if (ctl.fetch) begin
      hrd      <= hmem[hin_q];
      stack_rd <= smem[10'(free_top - 11'd1)];
    end
    if (ctl.rd_cnt) begin
      cnt_rdm <= cmem[cls_idx];
      cnt_rdv <= cnt_vld[cls_idx];
    end
    if (ctl.chk) begin
      owner_rd <= omem[{cls_idx, cnt_m1[7:0]}];
    end
  end

  // Placement divider
  assign prod = 14'((ctl.div_last ? last_q : slot_q) * cls_q);

  sca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (ctl.div_go),
    .dividend (prod),
    .divisor  (cbytes),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (ctl.lat_dst) begin
      dst_chunk <= div_quot;
      dst_off   <= div_rem;
    end
    if (ctl.lat_src) begin
      src_chunk_q <= div_quot;
      src_off_q   <= div_rem;
    end
  end

  // Table write ports
  always_comb begin
    h_we = 1'b0; h_wa = clr_idx;  h_wd = '0;
    o_we = 1'b0; o_wa = {6'(len_q - 7'd1), slot_q}; o_wd = stack_rd;
    c_we = 1'b0; c_wa = 6'(len_q - 7'd1); c_wd = 9'({1'b0, slot_q} + 9'd1);
    s_we = 1'b0; s_wa = clr_idx;  s_wd = ~clr_idx;
    if (ctl.clr_step) begin
      h_we = 1'b1;
      s_we = 1'b1;
    end else if (ctl.commit_a && ok && is_create) begin
      h_we = 1'b1; h_wa = stack_rd; h_wd = {1'b1, len_q, slot_q};
      o_we = 1'b1;
      c_we = 1'b1;
    end else if (ctl.commit_a && ok && is_remove) begin
      h_we = 1'b1; h_wa = hin_q; h_wd = {1'b0, cls_q, slot_q};
      o_we = moved; o_wa = {6'(cls_q - 7'd1), slot_q}; o_wd = owner_rd;
      c_we = 1'b1; c_wa = 6'(cls_q - 7'd1); c_wd = {1'b0, last_q};
      s_we = push_ok; s_wa = free_top[9:0]; s_wd = hin_q;
    end else if (ctl.commit_b && ok && is_remove && moved) begin
      h_we = 1'b1; h_wa = owner_rd; h_wd = {1'b1, cls_q, slot_q};
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    if (o_we) begin
      omem[o_wa] <= o_wd;
    end
    if (c_we) begin
      cmem[c_wa] <= c_wd;
    end
    if (s_we) begin
      smem[s_wa] <= s_wd;
    end
  end

  // Control state: count valid bits, stack pointer, clear index
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld  <= '0;
      free_top <= 11'(sca_pkg::MAX_HANDLES);
      clr_idx  <= '0;
    end else begin
      if (c_we) begin
        cnt_vld[c_wa] <= 1'b1;
      end
      if (ctl.clr_step) begin
        clr_idx <= clr_idx + 10'd1;
      end
      if (ctl.commit_a && ok && is_create) begin
        free_top <= free_top - 11'd1;
      end else if (ctl.commit_a && ok && is_remove && push_ok) begin
        free_top <= free_top + 11'd1;
      end
    end
  end

  // Split of the item across its start chunk
  always_comb begin
    room    = cbytes - {1'b0, dst_off};
    first_c = ({6'd0, cls_q} < room) ? cls_q : room[6:0];
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status       <= stat_q;
      handle_out   <= is_create ? (ok ? stack_rd : 10'd0) : hin_q;
      chunk_index  <= ok ? dst_chunk : 14'd0;
      offset       <= ok ? dst_off : 12'd0;
      first_len    <= ok ? first_c : 7'd0;
      second_len   <= ok ? 7'(cls_q - first_c) : 7'd0;
      src_chunk    <= (ok && is_remove) ? src_chunk_q : 14'd0;
      src_offset   <= (ok && is_remove) ? src_off_q : 12'd0;
      moved_valid  <= ok && is_remove && moved;
      moved_handle <= (ok && is_remove && moved) ? owner_rd : 10'd0;
      chunk_added  <= ok && is_create && ((dst_off == 12'd0)
                      || (13'({1'b0, dst_off} + {6'd0, cls_q}) > cbytes));
      chunk_freed  <= ok && is_remove && ((src_off_q == 12'd0)
                      || (13'({1'b0, src_off_q} + {6'd0, cls_q}) > cbytes));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sca_chk.sv -----
// ----------------------------------------------------------------------------
// sca_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module sca_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [9:0]  handle_out,
  input wire logic [2:0]  status,
  input wire logic [13:0] chunk_index,
  input wire logic        moved_valid,
  input wire logic        chunk_added,
  input wire logic        chunk_freed
);

  // An accepted command keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // One result per command, never back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held two cycles");

  // A bad length result carries no handle and no place
  a_bad_len_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == sca_pkg::ST_BAD_LEN) |-> (handle_out == 10'd0 && chunk_index == 14'd0))
    else $error("bad length result not cleared");

  // Moves and chunk flags only come with success
  a_flags_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (moved_valid || chunk_added || chunk_freed)) |-> (status == sca_pkg::ST_OK))
    else $error("flag set on failed command");

endmodule

bind size_class_packing_allocator sca_chk u_sca_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .handle_out  (handle_out),
  .status      (status),
  .chunk_index (chunk_index),
  .moved_valid (moved_valid),
  .chunk_added (chunk_added),
  .chunk_freed (chunk_freed)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the size class packing allocator: a local model
// of the class tables predicts each result, and a monitor compares every
// done cycle with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]  handle_out;
    logic [2:0]  status;
    logic [13:0] chunk_index;
    logic [11:0] offset;
    logic [6:0]  first_len;
    logic [6:0]  second_len;
    logic [13:0] src_chunk;
    logic [11:0] src_offset;
    logic        moved_valid;
    logic [9:0]  moved_handle;
    logic        chunk_added;
    logic        chunk_freed;
  } alloc_res_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int EXP_DEPTH = 16;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  cmd = sca_pkg::CMD_CREATE;
  logic [6:0]  item_length = '0;
  logic [9:0]  handle_in = '0;
  logic        cfg_valid = 1'b0;
  logic [12:0] cfg_data = '0;
  logic        busy, done, cfg_ready;
  logic [9:0]  handle_out;
  logic [2:0]  status;
  logic [13:0] chunk_index;
  logic [11:0] offset;
  logic [6:0]  first_len;
  logic [6:0]  second_len;
  logic [13:0] src_chunk;
  logic [11:0] src_offset;
  logic        moved_valid;
  logic [9:0]  moved_handle;
  logic        chunk_added;
  logic        chunk_freed;
  alloc_res_t  act;

  size_class_packing_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .item_length(item_length), .handle_in(handle_in),
    .done(done), .handle_out(handle_out), .status(status),
    .chunk_index(chunk_index), .offset(offset),
    .first_len(first_len), .second_len(second_len),
    .src_chunk(src_chunk), .src_offset(src_offset),
    .moved_valid(moved_valid), .moved_handle(moved_handle),
    .chunk_added(chunk_added), .chunk_freed(chunk_freed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  assign act = {handle_out, status, chunk_index, offset, first_len, second_len,
                src_chunk, src_offset, moved_valid, moved_handle, chunk_added,
                chunk_freed};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state of the allocator
  longint     chunk_sz;
  int         cls_fill [sca_pkg::MAX_LEN];
  bit         hdl_live [sca_pkg::MAX_HANDLES];
  int         hdl_len [sca_pkg::MAX_HANDLES];
  int         hdl_pos [sca_pkg::MAX_HANDLES];
  int         pos_owner [sca_pkg::MAX_LEN*sca_pkg::MAX_SLOTS];
  int         spare_stack [sca_pkg::MAX_HANDLES];
  int         spare_top;
  alloc_res_t exp_fifo [EXP_DEPTH];
  int         exp_wr = 0;
  int         exp_rd = 0;
  int         errors = 0;
  int         idle_pct = 0;
  longint     cycles = 0;

  function automatic bit is_live(int h);
    if (!hdl_live[h]) return 0;
    return hdl_len[h] >= 1 && hdl_len[h] <= sca_pkg::MAX_LEN &&
           hdl_pos[h] < cls_fill[hdl_len[h]-1];
  endfunction

  function automatic longint chunks_used(int len, int n);
    return (longint'(n) * len + chunk_sz - 1) / chunk_sz;
  endfunction

  // Fill chunk, offset and split lengths for slot s of class len
  function automatic void place_item(int len, int s, inout alloc_res_t r);
    longint addr, off, room, first;
    addr = longint'(s) * len;
    off = addr % chunk_sz;
    room = chunk_sz - off;
    first = (len < room) ? len : room;
    r.chunk_index = 14'(addr / chunk_sz);
    r.offset = 12'(off);
    r.first_len = 7'(first);
    r.second_len = 7'(len - first);
  endfunction

  function automatic alloc_res_t predict_alloc(logic [1:0] c, logic [6:0] len,
                                               logic [9:0] h);
    alloc_res_t r, src;
    int n, nh, cl, s, last, mh;
    r = '0;
    src = '0;
    if (c == sca_pkg::CMD_CREATE) begin
      if (len == 0 || len > sca_pkg::MAX_LEN || len > chunk_sz) begin
        r.status = sca_pkg::ST_BAD_LEN;
      end else if (cls_fill[len-1] >= sca_pkg::MAX_SLOTS) begin
        r.status = sca_pkg::ST_FULL;
      end else if (spare_top == 0) begin
        r.status = sca_pkg::ST_NO_HDL;
      end else begin
        n = cls_fill[len-1];
        spare_top--;
        nh = spare_stack[spare_top];
        hdl_live[nh] = 1;
        hdl_len[nh] = len;
        hdl_pos[nh] = n;
        pos_owner[(len-1)*sca_pkg::MAX_SLOTS+n] = nh;
        cls_fill[len-1] = n + 1;
        place_item(len, n, r);
        r.handle_out = 10'(nh);
        r.chunk_added = chunks_used(len, n+1) > chunks_used(len, n);
      end
    end else if (c == sca_pkg::CMD_REMOVE) begin
      r.handle_out = h;
      if (!is_live(h)) begin
        r.status = sca_pkg::ST_BAD_HDL;
      end else begin
        cl = hdl_len[h];
        s = hdl_pos[h];
        last = cls_fill[cl-1] - 1;
        place_item(cl, s, r);
        place_item(cl, last, src);
        r.src_chunk = src.chunk_index;
        r.src_offset = src.offset;
        if (s != last) begin
          mh = pos_owner[(cl-1)*sca_pkg::MAX_SLOTS+last];
          hdl_pos[mh] = s;
          pos_owner[(cl-1)*sca_pkg::MAX_SLOTS+s] = mh;
          r.moved_valid = 1'b1;
          r.moved_handle = 10'(mh);
        end
        r.chunk_freed = (src.offset == 0) || (longint'(src.offset) + cl > chunk_sz);
        cls_fill[cl-1] = last;
        hdl_live[h] = 0;
        spare_stack[spare_top] = h;
        spare_top++;
      end
    end else begin
      r.handle_out = h;
      if (c != sca_pkg::CMD_LOCATE || !is_live(h)) r.status = sca_pkg::ST_BAD_HDL;
      else place_item(hdl_len[h], hdl_pos[h], r);
    end
    return r;
  endfunction

  // Compare each done cycle with the oldest prediction
  always @(posedge clk) begin
    alloc_res_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else if (!rst && done) begin
      if (exp_wr == exp_rd) begin
        errors++;
        $display("%0t: unexpected result %p", $time, act);
      end else begin
        exp_r = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (act !== exp_r) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, act);
        end
      end
    end
  end

  // Send one command and record its prediction once busy is seen low; start stays high
  // after accept and is dropped only when idling
  task automatic send_item(logic [1:0] c, logic [6:0] len, logic [9:0] h);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    item_length <= len;
    handle_in <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_fifo[exp_wr % EXP_DEPTH] = predict_alloc(c, len, h);
    exp_wr++;
  endtask

  // Let the block drain, then write the chunk size
  task automatic write_chunk(logic [12:0] v);
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    chunk_sz = (v == 13'd0) ? 1 :
               (v > sca_pkg::CHUNK_MAX) ? longint'(sca_pkg::CHUNK_MAX) : longint'(v);
  endtask

  function automatic logic [9:0] pick_live();
    logic [9:0] h;
    h = 10'($urandom_range(sca_pkg::MAX_HANDLES-1));
    for (int i = 0; i < 30 && !hdl_live[h]; i++)
      h = 10'($urandom_range(sca_pkg::MAX_HANDLES-1));
    return h;
  endfunction

  task automatic test_directed();
    send_item(sca_pkg::CMD_CREATE, 7'd0, 10'd0);
    send_item(sca_pkg::CMD_CREATE, 7'd65, 10'd0);
    send_item(sca_pkg::CMD_CREATE, 7'd127, 10'h3ff);
    send_item(sca_pkg::CMD_CREATE, 7'd1, 10'd0);
    send_item(sca_pkg::CMD_CREATE, 7'd64, 10'd0);
    send_item(sca_pkg::CMD_CREATE, 7'd64, 10'd0);
    send_item(sca_pkg::CMD_CREATE, 7'd64, 10'd0);
    send_item(sca_pkg::CMD_LOCATE, 7'd0, 10'd1);
    send_item(sca_pkg::CMD_LOCATE, 7'd0, 10'h3ff);
    send_item(sca_pkg::CMD_REMOVE, 7'd0, 10'd1);
    send_item(sca_pkg::CMD_REMOVE, 7'd0, 10'd1);
    send_item(CMD_UNKNOWN, 7'd0, 10'd2);
    send_item(sca_pkg::CMD_LOCATE, 7'd0, 10'd2);
    // shrink chunks under live items, then reject too-long creates
    write_chunk(13'd0);
    send_item(sca_pkg::CMD_CREATE, 7'd2, 10'd0);
    send_item(sca_pkg::CMD_CREATE, 7'd1, 10'd0);
    send_item(sca_pkg::CMD_LOCATE, 7'd0, 10'd2);
    write_chunk(13'd100);
    send_item(sca_pkg::CMD_LOCATE, 7'd0, 10'd2);
    send_item(sca_pkg::CMD_REMOVE, 7'd0, 10'd0);
    write_chunk(13'h1fff);
    send_item(sca_pkg::CMD_LOCATE, 7'd0, 10'd3);
  endtask

  // Fill one class to its slot limit, overflow it once, then send forty removes of picked handles
  task automatic test_full_class();
    while (cls_fill[4] < sca_pkg::MAX_SLOTS) send_item(sca_pkg::CMD_CREATE, 7'd5, 10'd0);
    send_item(sca_pkg::CMD_CREATE, 7'd5, 10'd0);
    for (int i = 0; i < 40; i++) send_item(sca_pkg::CMD_REMOVE, 7'd0, pick_live());
  endtask

  task automatic test_random(int n);
    int k;
    logic [6:0] len;
    for (int i = 0; i < n; i++) begin
      k = int'($urandom_range(99));
      if (k < 45) begin
        if ($urandom_range(9) == 0) len = 7'($urandom_range(127));
        else len = 7'($urandom_range(sca_pkg::MAX_LEN, 1));
        send_item(sca_pkg::CMD_CREATE, len, 10'($urandom_range(1023)));
      end else if (k < 75) begin
        send_item(sca_pkg::CMD_REMOVE, 7'($urandom_range(127)),
                  ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : pick_live());
      end else if (k < 95) begin
        send_item(sca_pkg::CMD_LOCATE, 7'($urandom_range(127)),
                  ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : pick_live());
      end else begin
        send_item(CMD_UNKNOWN, 7'($urandom_range(127)), 10'($urandom_range(1023)));
      end
    end
  endtask

  initial begin
    chunk_sz = longint'(sca_pkg::CHUNK_RESET);
    spare_top = sca_pkg::MAX_HANDLES;
    for (int i = 0; i < sca_pkg::MAX_LEN; i++) cls_fill[i] = 0;
    for (int i = 0; i < sca_pkg::MAX_HANDLES; i++) begin
      hdl_live[i] = 0;
      spare_stack[i] = sca_pkg::MAX_HANDLES - 1 - i;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 12;
    test_directed();
    test_full_class();
    write_chunk(13'd7);
    test_random(14);
    write_chunk(13'd64);
    test_random(14);
    idle_pct = 72;
    write_chunk(13'd1);
    test_random(14);
    write_chunk(13'd4096);
    test_random(14);
    idle_pct = 0;
    write_chunk(13'($urandom_range(4096, 1)));
    test_random(14);
    write_chunk(13'd33);
    test_random(14);
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
